// File: src/lirc_pkg.sv
// lirc_pkg: shared constants, types and codes of the lattice index residual counter
// used by the channel interfaces and every module of the block
// depends on nothing
`default_nettype none

package lirc_pkg;

    // counter and field widths
    localparam int COUNT_BITS = 24;
    localparam int ENTRY_BITS = 21;
    localparam int COMP_BITS  = 24;
    localparam int PROD_BITS  = ENTRY_BITS + COMP_BITS;
    localparam int FRAC_BITS  = 32;
    localparam int SQ_BITS    = 2 * FRAC_BITS;
    localparam int ROWS       = 3;
    localparam int COLS       = 3;
    localparam int ROW_BITS   = COLS * ENTRY_BITS;
    localparam int TOL_BITS   = 17;
    localparam int TOL_FRAC   = 16;
    localparam int CFG_IDX_BITS = 2;

    // verdict queue between front and back
    localparam int QUEUE_DEPTH    = 8;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int FILL_BITS      = QUEUE_PTR_BITS + 1;
    localparam int CREDIT_BITS    = QUEUE_PTR_BITS + 2;

    typedef logic [COUNT_BITS-1:0] count_t;
    localparam count_t COUNT_MAX = {COUNT_BITS{1'b1}};

    // configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_ROW0 = 2'd0,
        REG_ROW1 = 2'd1,
        REG_ROW2 = 2'd2,
        REG_TOL  = 2'd3
    } cfg_reg_t;

    // classification of one vector
    typedef struct packed {
        logic hit;
        logic last;
    } verdict_t;

    // queue fill seen by the front
    typedef struct packed {
        logic [FILL_BITS-1:0] fill;
    } queue_status_t;

    // queue head seen by the back
    typedef struct packed {
        logic     valid;
        verdict_t verdict;
    } queue_head_t;

endpackage

`default_nettype wire

// File: src/lirc_channels.sv
// lirc channels: valid/ready interfaces for vectors, counts and register writes
// depends on lirc_pkg
`default_nettype none

interface lirc_vec_if;
    import lirc_pkg::*;
    logic                        valid;
    logic                        ready;
    logic signed [COMP_BITS-1:0] vec_x;
    logic signed [COMP_BITS-1:0] vec_y;
    logic signed [COMP_BITS-1:0] vec_z;
    logic                        last_vector;

    modport source (output valid, vec_x, vec_y, vec_z, last_vector, input ready);
    modport sink   (input valid, vec_x, vec_y, vec_z, last_vector, output ready);
endinterface

interface lirc_count_if;
    import lirc_pkg::*;
    logic   valid;
    logic   ready;
    count_t indexed_count;

    modport source (output valid, indexed_count, input ready);
    modport sink   (input valid, indexed_count, output ready);
endinterface

interface lirc_cfg_if;
    import lirc_pkg::*;
    logic                valid;
    logic                ready;
    cfg_reg_t            index;
    logic [ROW_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: src/lirc_front.sv
// lirc_front: register file, matrix product, residual squares and tolerance test
// depends on lirc_pkg and lirc_channels; pushes one verdict per vector
`default_nettype none

module lirc_front (
    input  wire                     clk,
    input  wire                     rst_n,
    lirc_vec_if.sink                vectors,
    lirc_cfg_if.sink                cfg,
    input  lirc_pkg::queue_status_t qstat,
    output logic                    push_valid,
    output lirc_pkg::verdict_t      push_data
);
    import lirc_pkg::*;

    logic [ROW_BITS-1:0]  matrix_reg [ROWS];
    logic [TOL_BITS-1:0]  tol_reg;

    logic                        s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic                        s1_last_reg, s2_last_reg, s3_last_reg;
    logic [FRAC_BITS-1:0]        prod_reg [ROWS][COLS];
    logic [FRAC_BITS-1:0]        mag_reg [ROWS];
    logic [SQ_BITS-1:0]          sq_reg [ROWS];

    logic signed [COMP_BITS-1:0] comp [COLS];
    logic signed [PROD_BITS-1:0] prod_full [ROWS][COLS];
    logic [FRAC_BITS-1:0]        prod_next [ROWS][COLS];
    logic [FRAC_BITS-1:0]        frac [ROWS];
    logic [FRAC_BITS-1:0]        mag_next [ROWS];
    logic [SQ_BITS-1:0]          sq_next [ROWS];
    logic [SQ_BITS-1:0]          sq_sum;
    logic [CREDIT_BITS-1:0]      in_use;
    logic                        accept;

    // register writes are always taken
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                matrix_reg[r] <= '0;
            end
            tol_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_ROW0: matrix_reg[0] <= cfg.data;
                REG_ROW1: matrix_reg[1] <= cfg.data;
                REG_ROW2: matrix_reg[2] <= cfg.data;
                REG_TOL:  tol_reg       <= cfg.data[TOL_BITS-1:0];
                default:  tol_reg       <= tol_reg;
            endcase
        end
    end

    // credit check: queue entries plus items still in the pipe
    assign in_use = CREDIT_BITS'(qstat.fill) + CREDIT_BITS'(s1_valid_reg)
                  + CREDIT_BITS'(s2_valid_reg) + CREDIT_BITS'(s3_valid_reg);
    assign vectors.ready = (in_use < CREDIT_BITS'(QUEUE_DEPTH));
    assign accept = vectors.valid && vectors.ready;

    // stage 1: nine products, only the fraction bits matter
    always_comb
    begin
        comp[0] = vectors.vec_x;
        comp[1] = vectors.vec_y;
        comp[2] = vectors.vec_z;
        for (int r = 0; r < ROWS; r++)
        begin
            for (int c = 0; c < COLS; c++)
            begin
                prod_full[r][c] = $signed(matrix_reg[r][ENTRY_BITS*c +: ENTRY_BITS])
                                * comp[c];
                prod_next[r][c] = prod_full[r][c][FRAC_BITS-1:0];
            end
        end
    end

    // stage 2: row sums modulo one, distance to nearest integer
    always_comb
    begin
        for (int r = 0; r < ROWS; r++)
        begin
            frac[r] = prod_reg[r][0] + prod_reg[r][1] + prod_reg[r][2];
            mag_next[r] = frac[r][FRAC_BITS-1] ? (~frac[r] + FRAC_BITS'(1)) : frac[r];
        end
    end

    // stage 3: squares
    always_comb
    begin
        for (int r = 0; r < ROWS; r++)
        begin
            sq_next[r] = SQ_BITS'(mag_reg[r]) * SQ_BITS'(mag_reg[r]);
        end
    end

    // stage 4: sum and tolerance compare, into the queue
    assign sq_sum = sq_reg[0] + sq_reg[1] + sq_reg[2];
    assign push_valid = s3_valid_reg;
    assign push_data.last = s3_last_reg;
    assign push_data.hit  = tol_reg[TOL_BITS-1]
        || (sq_sum < {tol_reg[TOL_FRAC-1:0], {(SQ_BITS-TOL_FRAC){1'b0}}});

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        s1_last_reg <= vectors.last_vector;
        s2_last_reg <= s1_last_reg;
        s3_last_reg <= s2_last_reg;
        for (int r = 0; r < ROWS; r++)
        begin
            for (int c = 0; c < COLS; c++)
            begin
                prod_reg[r][c] <= prod_next[r][c];
            end
            mag_reg[r] <= mag_next[r];
            sq_reg[r]  <= sq_next[r];
        end
    end

endmodule

`default_nettype wire

// File: src/lirc_queue.sv
// lirc_queue: short verdict queue between front and back
// depends on lirc_pkg
`default_nettype none

module lirc_queue (
    input  wire                     clk,
    input  wire                     rst_n,
    input  logic                    push_valid,
    input  lirc_pkg::verdict_t      push_data,
    input  logic                    pop,
    output lirc_pkg::queue_status_t qstat,
    output lirc_pkg::queue_head_t   head
);
    import lirc_pkg::*;

    verdict_t                  mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FILL_BITS-1:0]      fill_reg;
    logic                      do_pop;

    assign qstat.fill   = fill_reg;
    assign head.valid   = (fill_reg != '0);
    assign head.verdict = mem[rd_ptr_reg];
    assign do_pop       = pop && head.valid;

    // storage
    always_ff @(posedge clk)
    begin
        if (push_valid)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push_valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_BITS'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_BITS'(1);
            end
            fill_reg <= fill_reg + FILL_BITS'(push_valid) - FILL_BITS'(do_pop);
        end
    end

endmodule

`default_nettype wire

// File: src/lirc_back.sv
// lirc_back: saturating hit counter and result register
// depends on lirc_pkg and lirc_channels
`default_nettype none

module lirc_back (
    input  wire                   clk,
    input  wire                   rst_n,
    input  lirc_pkg::queue_head_t head,
    output logic                  pop,
    lirc_count_if.source          counts
);
    import lirc_pkg::*;

    count_t count_reg, count_next;
    count_t out_count_reg;
    logic   out_valid_reg;

    assign counts.valid         = out_valid_reg;
    assign counts.indexed_count = out_count_reg;

    // a set end needs the result register free, other verdicts always drain
    assign pop = head.valid
              && (!head.verdict.last || !out_valid_reg || counts.ready);

    assign count_next = count_reg
        + count_t'(head.verdict.hit && (count_reg != COUNT_MAX));

    // running count and output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                count_reg <= head.verdict.last ? '0 : count_next;
            end
            if (pop && head.verdict.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (counts.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (pop && head.verdict.last)
        begin
            out_count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: src/lattice_index_residual_counter.sv
// lattice_index_residual_counter: top level, front pipeline, verdict queue, counter
// depends on lirc_pkg, lirc_channels, lirc_front, lirc_queue, lirc_back
//
// Usage:
//   vectors: g-vectors (vec_x, vec_y, vec_z, signed Q3.20) plus last_vector.
//   counts:  one indexed_count per set, issued for the vector marked last;
//            it includes that vector and the count then restarts at zero.
//   cfg:     register writes (rows 0..2 of the Q8.12 matrix, squared
//            tolerance); always ready, write only while the block is idle.
// Timing:
//   one vector per cycle sustained while no stalled count backs up the queue.
//   A vector passes the front's product, residual and square registers, is
//   tested and written into the queue, and is counted when the back pops it.
//   The front takes vectors while the eight-entry verdict queue plus the
//   three front stages hold fewer than eight items.
// Reset: asynchronous, clears registers, running count, queue and outputs.
// Stall: a stalled count holds; verdicts without last keep draining, so
//   input stops only once the queue fills behind an unaccepted count.
`default_nettype none

module lattice_index_residual_counter (
    input  wire          clk,
    input  wire          rst_n,
    lirc_vec_if.sink     vectors,
    lirc_count_if.source counts,
    lirc_cfg_if.sink     cfg
);
    import lirc_pkg::*;

    logic          push_valid;
    verdict_t      push_data;
    logic          pop;
    queue_status_t qstat;
    queue_head_t   head;

    // classify incoming vectors
    lirc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .vectors    (vectors),
        .cfg        (cfg),
        .qstat      (qstat),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    // decouple front and back
    lirc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .pop        (pop),
        .qstat      (qstat),
        .head       (head)
    );

    // count and report
    lirc_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .counts (counts)
    );

endmodule

`default_nettype wire

// File: src/lirc_checker.sv
// lirc_checker: port level checks of the lattice index residual counter
// depends on lirc_pkg; bound to the top level below
`default_nettype none

module lirc_checker (
    input wire                clk,
    input wire                rst_n,
    input wire                out_valid,
    input wire                out_ready,
    input lirc_pkg::count_t   out_count
);
    import lirc_pkg::*;

    // a pending count stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("count dropped before transfer");

    // a pending count keeps its value
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_count))
        else $error("count changed while stalled");

    // no count can appear before a vector has crossed the pipeline
    a_no_early_count: assert property (@(posedge clk)
        $rose(rst_n) |-> ##3 !out_valid)
        else $error("count issued too soon after reset");

    // a count can only come from a vector taken after reset, which must first cross the pipeline
    a_count_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(rst_n, 4))
        else $error("count issued without time for a vector to pass");

endmodule

bind lattice_index_residual_counter lirc_checker u_lirc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (counts.valid),
    .out_ready (counts.ready),
    .out_count (counts.indexed_count)
);

`default_nettype wire

// File: tb/tb.sv
// tb: self-checking testbench of lattice_index_residual_counter
// streams g-vectors in sets, predicts each set's indexed count and checks the count channel
// depends on lirc_pkg, lirc_channels and the lattice_index_residual_counter top level
module tb;
    import lirc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // expected counts per set, from a private copy of the matrix, tolerance and counter
    class index_tally;
        logic [ROW_BITS-1:0] matrix_row [ROWS];
        logic [TOL_BITS-1:0] tol_sq;
        count_t              running;
        count_t              pending_counts [$];
        int                  errors;

        function new();
            for (int r = 0; r < ROWS; r++)
            begin
                matrix_row[r] = '0;
            end
            tol_sq  = '0;
            running = '0;
            errors  = 0;
        endfunction

        function void set_register(cfg_reg_t idx, logic [ROW_BITS-1:0] data);
            case (idx)
                REG_ROW0: matrix_row[0] = data;
                REG_ROW1: matrix_row[1] = data;
                REG_ROW2: matrix_row[2] = data;
                REG_TOL:  tol_sq = data[TOL_BITS-1:0];
                default:  ;
            endcase
        endfunction

        // classify one accepted vector and update the running count
        function void take_vector(logic signed [COMP_BITS-1:0] x, logic signed [COMP_BITS-1:0] y,
                                  logic signed [COMP_BITS-1:0] z, bit last);
            longint      g [COLS];
            longint      e;
            longint      h;
            logic [63:0] h_bits;
            logic [31:0] frac;
            logic [32:0] mag;
            logic [65:0] sum;
            bit          hit;
            g[0] = x;
            g[1] = y;
            g[2] = z;
            sum  = '0;
            for (int r = 0; r < ROWS; r++)
            begin
                h = 0;
                for (int c = 0; c < COLS; c++)
                begin
                    e = $signed(matrix_row[r][ENTRY_BITS*c +: ENTRY_BITS]);
                    h = h + e * g[c];
                end
                h_bits = h;
                frac   = h_bits[31:0];
                // distance to the nearest integer, a tie gives one half either way
                if (frac < 32'h8000_0000)
                    mag = {1'b0, frac};
                else
                    mag = 33'h1_0000_0000 - {1'b0, frac};
                sum = sum + mag * mag;
            end
            if (tol_sq[TOL_FRAC])
                hit = 1'b1;
            else
                hit = sum < {2'b00, tol_sq[TOL_FRAC-1:0], 48'd0};
            if (hit && running != COUNT_MAX)
                running = running + 1'b1;
            if (last)
            begin
                pending_counts.push_back(running);
                running = '0;
            end
        endfunction

        function void take_count(count_t actual);
            count_t want;
            if (pending_counts.size() == 0)
            begin
                $error("indexed_count: no count expected, actual %0d", actual);
                errors++;
            end
            else
            begin
                want = pending_counts.pop_front();
                if (want !== actual)
                begin
                    $error("indexed_count mismatch: expected %0d, actual %0d", want, actual);
                    errors++;
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    lirc_vec_if   vec_ch ();
    lirc_count_if cnt_ch ();
    lirc_cfg_if   cfg_ch ();

    lattice_index_residual_counter dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .vectors (vec_ch),
        .counts  (cnt_ch),
        .cfg     (cfg_ch)
    );

    index_tally tally = new();

    int sender_idle_pct;
    int receiver_idle_pct;
    int hold_requests;
    int holds_seen;
    int hold_left;

    localparam int HOLD_CYCLES = 80;
    localparam int ONE_COMP    = 1 << 20;

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // run limit
    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // count receiver: check transfers, random ready, long hold-off on request
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cnt_ch.valid && cnt_ch.ready)
                tally.take_count(cnt_ch.indexed_count);
            if (holds_seen != hold_requests)
            begin
                holds_seen = hold_requests;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                cnt_ch.ready <= 1'b0;
            end
            else
            begin
                cnt_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
            end
        end
    end

    // one vector transfer with random idle cycles ahead of it
    task automatic send_vector(logic signed [COMP_BITS-1:0] x, logic signed [COMP_BITS-1:0] y,
                               logic signed [COMP_BITS-1:0] z, bit last);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            vec_ch.valid <= 1'b0;
            @(posedge clk);
        end
        vec_ch.valid       <= 1'b1;
        vec_ch.vec_x       <= x;
        vec_ch.vec_y       <= y;
        vec_ch.vec_z       <= z;
        vec_ch.last_vector <= last;
        @(posedge clk);
        while (!vec_ch.ready)
        begin
            @(posedge clk);
        end
        tally.take_vector(x, y, z, last);
    endtask

    // stop sending, wait for every count, then let the pipeline empty
    task automatic wait_idle();
        vec_ch.valid <= 1'b0;
        @(posedge clk);
        while (tally.pending_counts.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [ROW_BITS-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        tally.set_register(idx, data);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // tolerance write with random junk above the register width
    task automatic write_tol(logic [TOL_BITS-1:0] tol);
        logic [ROW_BITS-1:0] junk;
        junk = {$urandom, $urandom};
        write_reg(REG_TOL, {junk[ROW_BITS-1:TOL_BITS], tol});
    endtask

    function automatic logic [ROW_BITS-1:0] pack_row(logic [ENTRY_BITS-1:0] c0,
                                                     logic [ENTRY_BITS-1:0] c1,
                                                     logic [ENTRY_BITS-1:0] c2);
        return {c2, c1, c0};
    endfunction

    // matrix row: full random, small integers, or small integers plus a little fraction
    function automatic logic [ROW_BITS-1:0] rand_row(int kind);
        logic [ENTRY_BITS-1:0] e [COLS];
        logic [63:0]           raw;
        int                    k;
        raw = {$urandom, $urandom};
        for (int c = 0; c < COLS; c++)
        begin
            k = (int'($urandom_range(6)) - 3) * 4096;
            if (kind == 2)
                k = k + int'($urandom_range(32)) - 16;
            e[c] = ENTRY_BITS'(k);
        end
        if (kind == 0)
            return raw[ROW_BITS-1:0];
        return pack_row(e[0], e[1], e[2]);
    endfunction

    // vector component: full random, near an integer, or exactly half way
    function automatic logic signed [COMP_BITS-1:0] rand_comp(int kind);
        int v;
        case (kind)
            0:       v = int'($urandom);
            1:       v = (int'($urandom_range(14)) - 7) * ONE_COMP + int'($urandom_range(64)) - 32;
            default: v = (int'($urandom_range(14)) - 7) * ONE_COMP + ONE_COMP / 2;
        endcase
        return COMP_BITS'(v);
    endfunction

    function automatic logic [TOL_BITS-1:0] rand_tol();
        case ($urandom_range(5))
            0:       return '0;
            1:       return 17'h10000;
            2:       return 17'h1FFFF;
            3:       return TOL_BITS'($urandom_range(17'h800));
            4:       return TOL_BITS'($urandom_range(17'hFFFF));
            default: return TOL_BITS'($urandom_range(17'h1FFFF));
        endcase
    endfunction

    // stimulus
    initial
    begin
        logic signed [COMP_BITS-1:0] cmax;
        logic signed [COMP_BITS-1:0] cmin;
        logic [ENTRY_BITS-1:0]       one;
        int                          sent;
        int                          len;
        int                          kind;
        bit                          last;

        cmax = 24'sh7FFFFF;
        cmin = 24'sh800000;
        one  = 21'd4096;

        rst_n              = 1'b0;
        vec_ch.valid       = 1'b0;
        vec_ch.vec_x       = '0;
        vec_ch.vec_y       = '0;
        vec_ch.vec_z       = '0;
        vec_ch.last_vector = 1'b0;
        cnt_ch.ready       = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = REG_ROW0;
        cfg_ch.data        = '0;
        sender_idle_pct    = 38;
        receiver_idle_pct  = 45;
        hold_requests      = 0;
        holds_seen         = 0;
        hold_left          = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers at reset: zero tolerance, nothing counts
        send_vector('0, '0, '0, 1'b0);
        send_vector(cmax, cmin, 24'sd1, 1'b1);
        wait_idle();

        // identity matrix, tolerance of one: every vector counts
        write_reg(REG_ROW0, pack_row(one, '0, '0));
        write_reg(REG_ROW1, pack_row('0, one, '0));
        write_reg(REG_ROW2, pack_row('0, '0, one));
        write_tol(17'h10000);
        send_vector(cmax, cmax, cmax, 1'b0);
        send_vector(cmin, cmin, cmin, 1'b0);
        send_vector(cmin, cmax, '0, 1'b1);
        wait_idle();

        // small tolerance: lattice points and near misses, a single tie
        write_tol(17'h00100);
        send_vector(ONE_COMP, -2 * ONE_COMP, 3 * ONE_COMP, 1'b0);
        send_vector(ONE_COMP / 2, '0, '0, 1'b0);
        send_vector(ONE_COMP + 16, -16, 5 * ONE_COMP - 1, 1'b0);
        send_vector(24'sh002000, '0, -24'sh002000, 1'b1);
        wait_idle();

        // three ties sum to exactly 0.75: not strictly below 0.75, below just above it
        write_tol(17'h0C000);
        send_vector(ONE_COMP / 2, 3 * ONE_COMP / 2, -ONE_COMP / 2, 1'b1);
        wait_idle();
        write_tol(17'h0C001);
        send_vector(ONE_COMP / 2, 3 * ONE_COMP / 2, -ONE_COMP / 2, 1'b1);
        wait_idle();

        // extreme matrix entries, largest tolerance
        write_reg(REG_ROW0, pack_row(21'h100000, 21'h0FFFFF, 21'h100000));
        write_reg(REG_ROW1, pack_row(21'h0FFFFF, 21'h100000, 21'h0FFFFF));
        write_reg(REG_ROW2, pack_row(21'h100000, 21'h100000, 21'h0FFFFF));
        write_tol(17'h1FFFF);
        send_vector(cmax, cmin, cmax, 1'b0);
        send_vector(cmin, cmin, cmax, 1'b1);
        wait_idle();

        // zero tolerance with junk in the upper data bits
        write_tol('0);
        send_vector(cmax, cmin, cmax, 1'b0);
        send_vector('0, '0, '0, 1'b1);
        wait_idle();

        // random phases: idle pattern changes every four phases
        for (int phase = 0; phase < 12; phase++)
        begin
            if (phase < 4)
            begin
                sender_idle_pct   = 38;
                receiver_idle_pct = 45;
            end
            else if (phase < 8)
            begin
                sender_idle_pct   = 45;
                receiver_idle_pct = 38;
            end
            else
            begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            kind = $urandom_range(2);
            write_reg(REG_ROW0, rand_row(kind));
            write_reg(REG_ROW1, rand_row(kind));
            write_reg(REG_ROW2, rand_row($urandom_range(2)));
            write_tol(rand_tol());

            sent = 0;
            // back-to-back last vectors against a stalled count channel
            if (phase == 2 || phase == 8)
            begin
                hold_requests++;
                for (int i = 0; i < 30; i++)
                begin
                    send_vector(rand_comp(0), rand_comp(1), rand_comp(2), 1'b1);
                    sent++;
                end
            end
            while (sent < 85)
            begin
                len  = $urandom_range(1, 12);
                kind = $urandom_range(4);
                for (int i = 0; i < len; i++)
                begin
                    last = (i == len - 1) || ($urandom_range(9) == 0);
                    if (kind < 2)
                        send_vector(rand_comp(0), rand_comp(0), rand_comp(0), last);
                    else if (kind < 4)
                        send_vector(rand_comp(1), rand_comp(1), rand_comp($urandom_range(2)),
                                    last);
                    else
                        send_vector(rand_comp(2), rand_comp(1), rand_comp(2), last);
                    sent++;
                end
            end
            wait_idle();
        end

        if (tally.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
